// ===== rtl/porq_pkg.sv =====
// Package: types, constants and codes shared by the ready queue modules.
`timescale 1ns / 1ps
package porq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int KEY_BITS    = 16;
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [ID_BITS-1:0]  thread_id;
        logic [KEY_BITS-1:0] preemption_count;
    } req_item_t;

    typedef struct packed {
        logic                found;
        logic                overflow;
        logic                head_valid;
        logic [ID_BITS-1:0]  head_id;
        logic [CNT_BITS-1:0] entry_count;
    } rsp_item_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } dp_cmd_t;

endpackage

// ===== rtl/porq_ctrl.sv =====
// Controller: sequences capture and execution of one item, owns both handshakes.
`timescale 1ns / 1ps
module porq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output porq_pkg::dp_cmd_t cmd
);
    import porq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   slot_free;

    // the result register may be reloaded in the cycle its item is taken
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall   = 1'b1;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.capture = req_valid;
            end
            ST_EXEC:
            begin
                cmd.execute = slot_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign rsp_valid_next = cmd.execute || (rsp_valid_reg && rsp_stall);
    assign rsp_valid      = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ===== rtl/porq_dp.sv =====
// Datapath: sorted slot chain with per-slot compare, item and result registers.
`timescale 1ns / 1ps
module porq_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  porq_pkg::dp_cmd_t   cmd,
    input  porq_pkg::req_item_t req,
    output porq_pkg::rsp_item_t rsp
);
    import porq_pkg::*;

    req_item_t           item_reg;
    rsp_item_t           rsp_reg;
    rsp_item_t           rsp_next;
    logic [ID_BITS-1:0]  ids_reg  [QUEUE_DEPTH];
    logic [ID_BITS-1:0]  ids_next [QUEUE_DEPTH];
    logic [KEY_BITS-1:0] keys_reg [QUEUE_DEPTH];
    logic [KEY_BITS-1:0] keys_next[QUEUE_DEPTH];
    logic [CNT_BITS-1:0] occ_reg;
    logic [CNT_BITS-1:0] occ_next;

    logic [QUEUE_DEPTH-1:0] held;
    logic [QUEUE_DEPTH-1:0] key_le;
    logic [QUEUE_DEPTH-1:0] prev_le;
    logic [QUEUE_DEPTH-1:0] id_hit;
    logic [QUEUE_DEPTH-1:0] past_hit;
    logic                   full;
    logic                   any_hit;
    logic                   hit_acc;

    // per-slot compares; held slots form a prefix, and so do key_le ones
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            held[i]   = CNT_BITS'(i) < occ_reg;
            key_le[i] = held[i] && (keys_reg[i] <= item_reg.preemption_count);
            id_hit[i] = held[i] && (ids_reg[i] == item_reg.thread_id);
        end
    end

    assign prev_le = {key_le[QUEUE_DEPTH-2:0], 1'b0};
    assign full    = occ_reg == CNT_BITS'(QUEUE_DEPTH);
    assign any_hit = |id_hit;

    // slots at and after the first matching id close up on removal
    always_comb
    begin
        hit_acc = 1'b0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            hit_acc     = hit_acc | id_hit[i];
            past_hit[i] = hit_acc;
        end
    end

    always_comb
    begin
        ids_next          = ids_reg;
        keys_next         = keys_reg;
        occ_next          = occ_reg;
        rsp_next.found    = 1'b0;
        rsp_next.overflow = 1'b0;
        unique case (item_reg.opcode)
            OP_INSERT:
            begin
                if (full)
                begin
                    rsp_next.overflow = 1'b1;
                end
                else
                begin
                    if (!key_le[0])
                    begin
                        ids_next[0]  = item_reg.thread_id;
                        keys_next[0] = item_reg.preemption_count;
                    end
                    for (int i = 1; i < QUEUE_DEPTH; i++)
                    begin
                        if (!key_le[i])
                        begin
                            if (prev_le[i])
                            begin
                                ids_next[i]  = item_reg.thread_id;
                                keys_next[i] = item_reg.preemption_count;
                            end
                            else
                            begin
                                ids_next[i]  = ids_reg[i-1];
                                keys_next[i] = keys_reg[i-1];
                            end
                        end
                    end
                    occ_next = occ_reg + CNT_BITS'(1);
                end
            end
            OP_REMOVE:
            begin
                rsp_next.found = any_hit;
                if (any_hit)
                begin
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                    begin
                        if (past_hit[i])
                        begin
                            ids_next[i]  = ids_reg[i+1];
                            keys_next[i] = keys_reg[i+1];
                        end
                    end
                    occ_next = occ_reg - CNT_BITS'(1);
                end
            end
            OP_LOOKUP:
            begin
                rsp_next.found = any_hit;
            end
            default:
            begin
                rsp_next.found = 1'b0;
            end
        endcase
        rsp_next.head_valid  = occ_next != '0;
        rsp_next.head_id     = (occ_next != '0) ? ids_next[0] : '0;
        rsp_next.entry_count = occ_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (cmd.execute)
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= req;
        end
        if (cmd.execute)
        begin
            ids_reg  <= ids_next;
            keys_reg <= keys_next;
            rsp_reg  <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== rtl/preemption_ordered_ready_queue.sv =====
// Top level: preemption-ordered ready queue of thread ids.
//
// Request channel (req_valid / req_stall / req) carries one operation:
// insert sorted by preemption count (equal counts stay in arrival order),
// remove the first entry with a given id, or look an id up. Unused opcodes
// change nothing. Response channel (rsp_valid / rsp_stall / rsp) returns
// one item per request: found, overflow, head id and validity, entry count.
// An insert into a full queue is dropped with overflow set.
// Each item is first registered, then executed: every slot of the
// 16-entry chain compares against it in parallel and shifts. The
// result is valid the cycle after the execute step, and the next item
// is accepted in the same cycle; no item is taken while one executes.
// While rsp is stalled, one more item can be taken; it then waits in its
// execute step until the result register is freed.
// Reset empties the queue and drops any pending result; slot contents are
// not cleared, as only held slots are ever read.
`timescale 1ns / 1ps
module preemption_ordered_ready_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  porq_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output porq_pkg::rsp_item_t rsp
);
    import porq_pkg::*;

    dp_cmd_t cmd;

    porq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    porq_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

    // one item at a time: an accepted item blocks the request side
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("item accepted while previous item still executing");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.entry_count <= CNT_BITS'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.overflow |-> rsp.entry_count == CNT_BITS'(QUEUE_DEPTH)
            && !rsp.found)
        else $error("overflow reported on a queue that is not full");

    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.head_valid == (rsp.entry_count != '0))
        else $error("head valid disagrees with entry count");

endmodule

// ===== test/tb.sv =====
// Testbench for the preemption-ordered ready queue: sorted inserts, removes, lookups.
`timescale 1ns / 1ps
module tb;
    import porq_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         IDLE_LIMIT = 2000;
    localparam int         SEGMENTS   = 12;
    localparam int         SEG_ITEMS  = 160;

    typedef enum {
        STALL_NONE,
        STALL_HALF,
        STALL_RARE,
        STALL_RUNS
    } stall_mode_t;

    // Tracks the queue contents and holds the responses still owed by the block.
    class porq_tracker;
        logic [ID_BITS-1:0]  ids  [QUEUE_DEPTH];
        logic [KEY_BITS-1:0] keys [QUEUE_DEPTH];
        int                  held;
        rsp_item_t           due_rsp [$];
        int                  errors;
        int                  checked;
        int                  drops;
        int                  remove_hits;
        int                  peak;

        function rsp_item_t apply_request(req_item_t r);
            rsp_item_t o;
            int        pos;
            int        hit;
            o   = '0;
            hit = -1;
            for (int i = 0; i < held; i++)
                if (hit < 0 && ids[i] == r.thread_id)
                    hit = i;
            case (r.opcode)
                OP_INSERT:
                begin
                    if (held == QUEUE_DEPTH)
                        o.overflow = 1'b1;
                    else
                    begin
                        // equal keys queue up behind each other
                        pos = 0;
                        while (pos < held && keys[pos] <= r.preemption_count)
                            pos++;
                        for (int i = held; i > pos; i--)
                        begin
                            ids[i]  = ids[i-1];
                            keys[i] = keys[i-1];
                        end
                        ids[pos]  = r.thread_id;
                        keys[pos] = r.preemption_count;
                        held++;
                    end
                end
                OP_REMOVE:
                begin
                    if (hit >= 0)
                    begin
                        o.found = 1'b1;
                        for (int i = hit; i + 1 < held; i++)
                        begin
                            ids[i]  = ids[i+1];
                            keys[i] = keys[i+1];
                        end
                        held--;
                    end
                end
                OP_LOOKUP:
                    o.found = (hit >= 0);
                default:
                    ;
            endcase
            o.head_valid  = (held != 0);
            o.head_id     = (held != 0) ? ids[0] : '0;
            o.entry_count = CNT_BITS'(held);
            return o;
        endfunction

        function void note_request(req_item_t r);
            rsp_item_t e;
            e = apply_request(r);
            if (e.overflow)
                drops++;
            if (r.opcode == OP_REMOVE && e.found)
                remove_hits++;
            if (held > peak)
                peak = held;
            due_rsp.push_back(e);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_response(rsp_item_t a);
            rsp_item_t e;
            if (due_rsp.size() == 0)
            begin
                $error("response with nothing outstanding: head_id %0d count %0d",
                       a.head_id, a.entry_count);
                errors++;
                return;
            end
            e = due_rsp.pop_front();
            checked++;
            compare_field("found",       32'(e.found),       32'(a.found));
            compare_field("overflow",    32'(e.overflow),    32'(a.overflow));
            compare_field("head_valid",  32'(e.head_valid),  32'(a.head_valid));
            compare_field("head_id",     32'(e.head_id),     32'(a.head_id));
            compare_field("entry_count", 32'(e.entry_count), 32'(a.entry_count));
        endfunction

        function logic [ID_BITS-1:0] any_held_id();
            return ids[$urandom_range(0, held - 1)];
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_item_t   req;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_item_t   rsp;

    porq_tracker tracker = new;
    int          idle_cycles = 0;
    int          sent = 0;
    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left = 0;
    int          run_left = 0;

    preemption_ordered_ready_queue i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #6;
        clk = 1'b1;
        #6;
        clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                tracker.note_request(req);
            if (rsp_valid && !rsp_stall)
                tracker.check_response(rsp);
        end
    end

    // Receiver back-pressure: a mode is picked for a stretch of cycles at a time.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= stall_mode_t'($urandom_range(0, 3));
                mode_left  <= $urandom_range(50, 300);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                STALL_NONE: rsp_stall <= 1'b0;
                STALL_HALF: rsp_stall <= 1'($urandom_range(0, 1));
                STALL_RARE: rsp_stall <= ($urandom_range(0, 7) == 0);
                default:
                begin
                    if (run_left == 0)
                    begin
                        run_left  <= $urandom_range(1, 24);
                        rsp_stall <= ~rsp_stall;
                    end
                    else
                        run_left <= run_left - 1;
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
            $display("[preemption_ordered_ready_queue] ERROR");
            $finish;
        end
    end

    task automatic send_item(input req_item_t r);
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_op(input logic [1:0] op, input logic [ID_BITS-1:0] id,
                           input logic [KEY_BITS-1:0] key);
        req_item_t r;
        r.opcode           = op;
        r.thread_id        = id;
        r.preemption_count = key;
        send_item(r);
    endtask

    task automatic idle_for(input int cycles);
        req_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Sender holds off until the block owes nothing.
    task automatic drain_responses();
        req_valid <= 1'b0;
        @(posedge clk);
        while (tracker.due_rsp.size() != 0)
            @(posedge clk);
    endtask

    // Removes and lookups mostly name a held id; other ids come from a narrow
    // pool half the time and keys often do too, so duplicates and equal keys turn up often.
    function automatic req_item_t random_request(input int insert_pct);
        req_item_t r;
        int        roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            r.opcode = OP_UNUSED;
        else if (roll < 3 + insert_pct)
            r.opcode = OP_INSERT;
        else if ($urandom_range(0, 99) < 60)
            r.opcode = OP_REMOVE;
        else
            r.opcode = OP_LOOKUP;

        if (r.opcode != OP_INSERT && tracker.held > 0 && $urandom_range(0, 99) < 75)
            r.thread_id = tracker.any_held_id();
        else if ($urandom_range(0, 1) == 0)
            r.thread_id = ID_BITS'($urandom_range(0, 15));
        else
            r.thread_id = ID_BITS'($urandom_range(0, 255));

        roll = $urandom_range(0, 99);
        if (roll < 35)
            r.preemption_count = KEY_BITS'($urandom_range(0, 7));
        else if (roll < 45)
            r.preemption_count = $urandom_range(0, 1) ? '1 : '0;
        else
            r.preemption_count = KEY_BITS'($urandom_range(0, 65535));
        return r;
    endfunction

    initial
    begin
        int insert_pct;
        int burst;
        int seg_sent;
        req_valid <= 1'b0;
        req       <= '0;
        rst_n     <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue: remove, lookup and an unused opcode change nothing
        send_op(OP_REMOVE, 8'h00, 16'hffff);
        send_op(OP_LOOKUP, 8'hff, 16'h0000);
        send_op(OP_UNUSED, 8'h55, 16'haaaa);
        // key extremes, equal keys in arrival order, a duplicate id
        send_op(OP_INSERT, 8'hff, 16'hffff);
        send_op(OP_INSERT, 8'h00, 16'h0000);
        send_op(OP_INSERT, 8'h07, 16'd100);
        send_op(OP_INSERT, 8'h08, 16'd100);
        send_op(OP_INSERT, 8'h07, 16'd100);
        send_op(OP_LOOKUP, 8'h08, 16'h0000);
        send_op(OP_REMOVE, 8'h07, 16'h0000);
        send_op(OP_REMOVE, 8'h99, 16'h0000);
        // fill up, then one insert too many
        repeat (QUEUE_DEPTH - 4)
            send_op(OP_INSERT, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        send_op(OP_INSERT, 8'h3c, 16'h1234);
        send_op(OP_LOOKUP, 8'hff, 16'h0000);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg % 4)
                0:       insert_pct = 72;
                1:       insert_pct = 48;
                2:       insert_pct = 20;
                default: insert_pct = 42;
            endcase
            seg_sent = 0;
            while (seg_sent < SEG_ITEMS)
            begin
                burst = $urandom_range(1, 40);
                for (int k = 0; k < burst && seg_sent < SEG_ITEMS; k++)
                begin
                    send_item(random_request(insert_pct));
                    seg_sent++;
                end
                if ($urandom_range(0, 3) != 0)
                    idle_for($urandom_range(1, 12));
            end
            if (seg == 3 || seg == 8)
                drain_responses();
        end

        drain_responses();
        repeat (10) @(posedge clk);

        $display("sent %0d requests, checked %0d responses, peak occupancy %0d",
                 sent, tracker.checked, tracker.peak);
        $display("inserts dropped on a full queue: %0d, removes that hit: %0d",
                 tracker.drops, tracker.remove_hits);
        if (tracker.errors == 0 && tracker.due_rsp.size() == 0)
            $display("[preemption_ordered_ready_queue] OK");
        else
            $display("[preemption_ordered_ready_queue] ERROR");
        $finish;
    end
endmodule

// ===== preemption_ordered_ready_queue.f =====
rtl/porq_pkg.sv
rtl/porq_ctrl.sv
rtl/porq_dp.sv
rtl/preemption_ordered_ready_queue.sv
test/tb.sv
